FILE: rtl/stc_pkg.sv
// Shared types and codes for the safe text to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none
package stc_pkg;

  // text_encoding register values
  localparam logic [1:0] EncAscii   = 2'd0;
  localparam logic [1:0] EncUtf8    = 2'd1;
  localparam logic [1:0] EncUtf16Le = 2'd2;
  localparam logic [1:0] EncUtf16Be = 2'd3;

  // result kinds
  localparam logic [2:0] KindData   = 3'd0;
  localparam logic [2:0] KindOk     = 3'd1;
  localparam logic [2:0] KindEmpty  = 3'd2;
  localparam logic [2:0] KindBadEnc = 3'd3;
  localparam logic [2:0] KindCtrl   = 3'd4;

  // configuration register index (byte address / 4)
  localparam logic RegTextEncoding = 1'b0;

  localparam int unsigned QueueDepth = 4;

  // one record of work from the front end: data bytes, then an optional end result
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      n_bytes;
    logic            has_end;
    logic [2:0]      kind;
    logic [20:0]     cp;
  } rec_t;

endpackage
`default_nettype wire

FILE: rtl/stc_front.sv
// Front end: validates input bytes and builds result records.
`timescale 1ns / 1ps
`default_nettype none
module stc_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  enc_i,
  input  wire logic        clr_i,
  input  wire logic        in_fire_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        in_last_i,
  output stc_pkg::rec_t    rec_o,
  output logic             push_o
);

  function automatic logic is_ctrl(input logic [20:0] cp);
    is_ctrl = (cp <= 21'h1F) || (cp == 21'h7F) || (cp >= 21'h80 && cp <= 21'h9F);
  endfunction

  logic [3:0][7:0] held_q, held_d;
  logic [2:0]      needed_q, needed_d;
  logic [2:0]      seen_q, seen_d;
  logic [20:0]     acc_q, acc_d;
  logic [7:0]      first_q, first_d;
  logic            half_q, half_d;
  logic [10:0]     pend_q, pend_d;
  logic            drop_q, drop_d;
  logic            saw_q, saw_d;

  logic [15:0]     unit;
  logic [20:0]     u16_cp;
  logic [3:0][7:0] enc_bytes;
  logic [2:0]      enc_n;

  // UTF-16 code unit and code point
  always_comb begin
    if (enc_i == stc_pkg::EncUtf16Le) begin
      unit = {in_byte_i, first_q};
    end else begin
      unit = {first_q, in_byte_i};
    end
    if (pend_q[10]) begin
      u16_cp = 21'h10000 + {1'b0, pend_q[9:0], unit[9:0]};
    end else begin
      u16_cp = {5'd0, unit};
    end
  end

  // UTF-8 encoding of the UTF-16 code point
  always_comb begin
    enc_bytes = '0;
    if (u16_cp <= 21'h7F) begin
      enc_bytes[0] = u16_cp[7:0];
      enc_n = 3'd1;
    end else if (u16_cp <= 21'h7FF) begin
      enc_bytes[0] = {3'b110, u16_cp[10:6]};
      enc_bytes[1] = {2'b10, u16_cp[5:0]};
      enc_n = 3'd2;
    end else if (u16_cp <= 21'hFFFF) begin
      enc_bytes[0] = {4'b1110, u16_cp[15:12]};
      enc_bytes[1] = {2'b10, u16_cp[11:6]};
      enc_bytes[2] = {2'b10, u16_cp[5:0]};
      enc_n = 3'd3;
    end else begin
      enc_bytes[0] = {5'b11110, u16_cp[20:18]};
      enc_bytes[1] = {2'b10, u16_cp[17:12]};
      enc_bytes[2] = {2'b10, u16_cp[11:6]};
      enc_bytes[3] = {2'b10, u16_cp[5:0]};
      enc_n = 3'd4;
    end
  end

  logic        err;
  logic [2:0]  err_kind;
  logic [20:0] err_cp;
  logic        clr;
  logic [20:0] acc_new;
  logic [2:0]  seen_new;
  logic [7:0]  b0;

  always_comb begin
    held_d   = held_q;
    needed_d = needed_q;
    seen_d   = seen_q;
    acc_d    = acc_q;
    first_d  = first_q;
    half_d   = half_q;
    pend_d   = pend_q;
    drop_d   = drop_q;
    saw_d    = saw_q;
    rec_o    = '0;
    push_o   = 1'b0;
    err      = 1'b0;
    err_kind = stc_pkg::KindData;
    err_cp   = '0;
    clr      = 1'b0;
    acc_new  = {acc_q[14:0], in_byte_i[5:0]};
    seen_new = seen_q + 3'd1;
    b0       = held_q[0];

    if (in_fire_i) begin
      if (drop_q) begin
        clr = in_last_i;
      end else begin
        if (has_byte_i) begin
          saw_d = 1'b1;
          case (enc_i)
            stc_pkg::EncAscii: begin
              if (in_byte_i[7]) begin
                err = 1'b1;
                err_kind = stc_pkg::KindBadEnc;
              end else if (is_ctrl({13'd0, in_byte_i})) begin
                err = 1'b1;
                err_kind = stc_pkg::KindCtrl;
                err_cp = {13'd0, in_byte_i};
              end else begin
                rec_o.data[0] = in_byte_i;
                rec_o.n_bytes = 3'd1;
              end
            end
            stc_pkg::EncUtf16Le, stc_pkg::EncUtf16Be: begin
              if (!half_q) begin
                first_d = in_byte_i;
                half_d  = 1'b1;
              end else begin
                half_d = 1'b0;
                if (pend_q[10]) begin
                  pend_d = '0;
                  if (unit[15:10] != 6'b110111) begin
                    err = 1'b1;
                    err_kind = stc_pkg::KindBadEnc;
                  end
                end else if (unit[15:10] == 6'b110110) begin
                  pend_d = {1'b1, unit[9:0]};
                end else if (unit[15:10] == 6'b110111) begin
                  err = 1'b1;
                  err_kind = stc_pkg::KindBadEnc;
                end
                // emit only when no surrogate is left waiting
                if (!err && !(!pend_q[10] && unit[15:10] == 6'b110110)) begin
                  if (is_ctrl(u16_cp)) begin
                    err = 1'b1;
                    err_kind = stc_pkg::KindCtrl;
                    err_cp = u16_cp;
                  end else begin
                    rec_o.data    = enc_bytes;
                    rec_o.n_bytes = enc_n;
                  end
                end
              end
            end
            default: begin
              if (seen_q == 3'd0) begin
                if (!in_byte_i[7]) begin
                  if (is_ctrl({13'd0, in_byte_i})) begin
                    err = 1'b1;
                    err_kind = stc_pkg::KindCtrl;
                    err_cp = {13'd0, in_byte_i};
                  end else begin
                    rec_o.data[0] = in_byte_i;
                    rec_o.n_bytes = 3'd1;
                  end
                end else begin
                  if (in_byte_i >= 8'hC2 && in_byte_i <= 8'hDF) begin
                    needed_d = 3'd2;
                    acc_d = {16'd0, in_byte_i[4:0]};
                  end else if (in_byte_i >= 8'hE0 && in_byte_i <= 8'hEF) begin
                    needed_d = 3'd3;
                    acc_d = {17'd0, in_byte_i[3:0]};
                  end else if (in_byte_i >= 8'hF0 && in_byte_i <= 8'hF4) begin
                    needed_d = 3'd4;
                    acc_d = {18'd0, in_byte_i[2:0]};
                  end else begin
                    err = 1'b1;
                    err_kind = stc_pkg::KindBadEnc;
                  end
                  held_d[0] = in_byte_i;
                  seen_d = 3'd1;
                end
              end else if (in_byte_i[7:6] != 2'b10) begin
                err = 1'b1;
                err_kind = stc_pkg::KindBadEnc;
              end else if (seen_q == 3'd1 &&
                           ((b0 == 8'hE0 && in_byte_i < 8'hA0) ||
                            (b0 == 8'hED && in_byte_i >= 8'hA0) ||
                            (b0 == 8'hF0 && in_byte_i < 8'h90) ||
                            (b0 == 8'hF4 && in_byte_i >= 8'h90))) begin
                err = 1'b1;
                err_kind = stc_pkg::KindBadEnc;
              end else begin
                held_d[seen_q[1:0]] = in_byte_i;
                if (seen_new < needed_q) begin
                  acc_d  = acc_new;
                  seen_d = seen_new;
                end else if (acc_new > 21'h10FFFF ||
                             (acc_new >= 21'hD800 && acc_new <= 21'hDFFF)) begin
                  err = 1'b1;
                  err_kind = stc_pkg::KindBadEnc;
                end else if (is_ctrl(acc_new)) begin
                  err = 1'b1;
                  err_kind = stc_pkg::KindCtrl;
                  err_cp = acc_new;
                end else begin
                  for (int i = 0; i < 4; i++) begin
                    if (i[1:0] == seen_q[1:0]) begin
                      rec_o.data[i[1:0]] = in_byte_i;
                    end else begin
                      rec_o.data[i[1:0]] = held_q[i[1:0]];
                    end
                  end
                  rec_o.n_bytes = needed_q;
                  needed_d = '0;
                  seen_d   = '0;
                  acc_d    = '0;
                end
              end
            end
          endcase
        end

        if (err) begin
          rec_o         = '0;
          rec_o.has_end = 1'b1;
          rec_o.kind    = err_kind;
          rec_o.cp      = err_cp;
          push_o        = 1'b1;
          clr           = 1'b1;
        end else begin
          if (in_last_i) begin
            rec_o.has_end = 1'b1;
            clr = 1'b1;
            if (!saw_d) begin
              rec_o.kind = stc_pkg::KindEmpty;
            end else if (seen_d != 3'd0 || half_d || pend_d[10]) begin
              rec_o.kind = stc_pkg::KindBadEnc;
            end else begin
              rec_o.kind = stc_pkg::KindOk;
            end
          end
          push_o = in_last_i || (rec_o.n_bytes != 3'd0);
        end
      end
    end

    if (clr || clr_i) begin
      needed_d = '0;
      seen_d   = '0;
      acc_d    = '0;
      first_d  = '0;
      half_d   = 1'b0;
      pend_d   = '0;
      drop_d   = 1'b0;
      saw_d    = 1'b0;
    end
    // an error before the last item silences the rest of the string
    if (!clr_i && in_fire_i && !drop_q && err && !in_last_i) begin
      drop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needed_q <= '0;
      seen_q   <= '0;
      acc_q    <= '0;
      first_q  <= '0;
      half_q   <= 1'b0;
      pend_q   <= '0;
      drop_q   <= 1'b0;
      saw_q    <= 1'b0;
    end else begin
      needed_q <= needed_d;
      seen_q   <= seen_d;
      acc_q    <= acc_d;
      first_q  <= first_d;
      half_q   <= half_d;
      pend_q   <= pend_d;
      drop_q   <= drop_d;
      saw_q    <= saw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule
`default_nettype wire

FILE: rtl/stc_fifo.sv
// Record queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module stc_fifo #(
  parameter int unsigned Depth = stc_pkg::QueueDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  stc_pkg::rec_t wdata_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output stc_pkg::rec_t rdata_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  stc_pkg::rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stc_back.sv
// Output sequencer: record bytes, then any end result; one per cycle while ready.
`timescale 1ns / 1ps
`default_nettype none
module stc_back (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    head_valid_i,
  input  stc_pkg::rec_t head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  output logic [7:0]   out_byte_o,
  output logic [2:0]   out_kind_o,
  output logic [20:0]  out_cp_o,
  output logic         out_eos_o,
  input  wire logic    out_ready_i
);

  logic [2:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic [2:0]  kind_q, kind_d;
  logic [20:0] cp_q, cp_d;
  logic        eos_q, eos_d;
  logic        load;

  assign load        = head_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_kind_o  = kind_q;
  assign out_cp_o    = cp_q;
  assign out_eos_o   = eos_q;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && !out_ready_i;
    byte_d  = byte_q;
    kind_d  = kind_q;
    cp_d    = cp_q;
    eos_d   = eos_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      if (idx_q < head_i.n_bytes) begin
        byte_d = head_i.data[idx_q[1:0]];
        kind_d = stc_pkg::KindData;
        cp_d   = '0;
        eos_d  = 1'b0;
        if ((idx_q + 3'd1 == head_i.n_bytes) && !head_i.has_end) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end else begin
        byte_d = '0;
        kind_d = head_i.kind;
        cp_d   = head_i.cp;
        eos_d  = 1'b1;
        pop_o  = 1'b1;
        idx_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
    cp_q   <= cp_d;
    eos_q  <= eos_d;
  end

endmodule
`default_nettype wire

FILE: rtl/safe_text_to_utf8_transcoder.sv
// Top level of the validating text to UTF-8 transcoder.
//
//  channel  | direction | signals
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata: in_byte; tuser: has_byte; tlast: in_last
//  m_axis   | out       | tdata: out_byte, bad_codepoint; tuser: kind;
//           |           | tlast: end_of_string
//  apb      | config    | register 0 at address 0: text_encoding
//
// The front end takes one input transfer per cycle while the record queue has room.
// The output side sends one result per cycle while m_axis is ready: each UTF-8
// byte of a character, then the string's end result; the output register sets that pace.
// Either side may stall; the queue holds QueueDepth records between them.
// After reset the encoding is UTF-8 and no string is in progress.
`timescale 1ns / 1ps
`default_nettype none
module safe_text_to_utf8_transcoder #(
  parameter int unsigned QueueDepth = stc_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] has_byte
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [7:0] out_byte, [28:8] bad_codepoint
  output logic [2:0]       m_axis_tuser_o,   // [2:0] kind
  output logic             m_axis_tlast_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  logic [1:0]    enc_q, enc_d;
  logic          cfg_we;
  logic          in_fire;
  logic          full;
  logic          push;
  logic          pop;
  logic          head_valid;
  stc_pkg::rec_t rec_in;
  stc_pkg::rec_t head;
  logic [7:0]    out_byte;
  logic [20:0]   out_cp;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o &&
                    (paddr_i[2] == stc_pkg::RegTextEncoding);
  assign enc_d    = cfg_we ? pwdata_i[1:0] : enc_q;
  assign prdata_o = {30'd0, enc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q <= stc_pkg::EncUtf8;
    end else begin
      enc_q <= enc_d;
    end
  end

  assign s_axis_tready_o = !full;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  stc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enc_i      (enc_q),
    .clr_i      (cfg_we),
    .in_fire_i  (in_fire),
    .in_byte_i  (s_axis_tdata_i),
    .has_byte_i (s_axis_tuser_i[0]),
    .in_last_i  (s_axis_tlast_i),
    .rec_o      (rec_in),
    .push_o     (push)
  );

  stc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head)
  );

  stc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_byte_o   (out_byte),
    .out_kind_o   (m_axis_tuser_o),
    .out_cp_o     (out_cp),
    .out_eos_o    (m_axis_tlast_o),
    .out_ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {3'd0, out_cp, out_byte};

endmodule
`default_nettype wire
